// File: hdl/mi3inv_pkg.sv
`timescale 1ns / 1ps

package mi3inv_pkg;

    localparam int MW = 24;                   // matrix entry, Q8.16
    localparam int NE = 9;                    // entries in a 3x3 matrix
    localparam int PW = 2 * MW;               // 2x2 cofactor product
    localparam int AW = PW + 1;               // cofactor (adjugate entry)
    localparam int LOW = 25;                  // low slice of a cofactor for the det multiply
    localparam int HIW = AW - LOW;            // high slice, signed
    localparam int PLW = MW + LOW + 1;        // entry times low slice
    localparam int PHW = MW + HIW;            // entry times high slice
    localparam int TW = MW + AW;              // one determinant term
    localparam int EW = TW + 2;               // exact determinant at 2^-48
    localparam int FRAC_DROP = 16;            // 2^-48 down to 2^-32
    localparam int RW = 57;                   // rounded determinant magnitude
    localparam int DW = 58;                   // determinant port, Q26.32
    localparam int CW = 57;                   // substitute register
    localparam int NW = 64;                   // dividend
    localparam int QB = 33;                   // quotient bits produced
    localparam int SW = RW + QB;              // widest shifted divisor
    localparam int OW = 32;                   // inverse entry, Q16.16
    localparam int DSTG = 6;                  // determinant pipeline stages

    localparam logic [EW-1:0] ROUND_HALF = EW'(1) << (FRAC_DROP - 1);
    localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW - 1){1'b1}}};
    localparam logic [OW-1:0] NEG_MIN = {1'b1, {(OW - 1){1'b0}}};

    typedef logic signed [MW-1:0] elem_t;
    typedef elem_t mat_t [NE];
    typedef elem_t row_t [3];
    typedef logic signed [AW-1:0] adj_t;
    typedef adj_t adj_arr_t [NE];
    typedef logic signed [OW-1:0] inv_t;
    typedef inv_t inv_arr_t [NE];

    typedef struct packed {
        logic signed [DW-1:0] det;
        logic                 singular;
    } det_info_t;

    // Each adjugate entry is m[a]*m[b] - m[c]*m[d], row-major indices.
    localparam logic [3:0] ADJ_IDX [NE][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

// File: hdl/mi3inv_cof.sv
`timescale 1ns / 1ps

module mi3inv_cof (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  mi3inv_pkg::mat_t     m,
    output logic                 out_valid,
    output mi3inv_pkg::adj_arr_t adj,
    output mi3inv_pkg::row_t     row0
);
    import mi3inv_pkg::*;

    logic signed [PW-1:0] prod_reg [NE][2];
    row_t                 row_a_reg;
    row_t                 row_b_reg;
    adj_arr_t             adj_reg;
    logic                 valid_a_reg;
    logic                 valid_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NE; i++)
            begin
                prod_reg[i][0] <= m[ADJ_IDX[i][0]] * m[ADJ_IDX[i][1]];
                prod_reg[i][1] <= m[ADJ_IDX[i][2]] * m[ADJ_IDX[i][3]];
                adj_reg[i]     <= AW'(prod_reg[i][0]) - AW'(prod_reg[i][1]);
            end
            for (int j = 0; j < 3; j++)
            begin
                row_a_reg[j] <= m[j];
                row_b_reg[j] <= row_a_reg[j];
            end
        end
    end

    assign out_valid = valid_b_reg;
    assign adj       = adj_reg;
    assign row0      = row_b_reg;

endmodule

// File: hdl/mi3inv_det.sv
`timescale 1ns / 1ps

module mi3inv_det (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  mi3inv_pkg::adj_arr_t  adj,
    input  mi3inv_pkg::row_t      row0,
    input  logic [mi3inv_pkg::CW-1:0] subst,
    output logic                  out_valid,
    output mi3inv_pkg::adj_arr_t  adj_out,
    output mi3inv_pkg::det_info_t info
);
    import mi3inv_pkg::*;

    logic                  vld_reg [DSTG];
    adj_arr_t              adj_pipe_reg [DSTG];
    logic signed [PLW-1:0] plo_reg [3];
    logic signed [PHW-1:0] phi_reg [3];
    logic signed [TW-1:0]  term_reg [3];
    logic signed [EW-1:0]  sum_reg;
    logic [EW-2:0]         mag_reg;
    logic                  sign_f_reg;
    logic                  sign_g_reg;
    logic [RW-1:0]         r_reg;
    det_info_t             info_reg;

    logic signed [EW-1:0]  mag_c;
    logic [EW-1:0]         rsum_c;
    logic [CW-1:0]         subst_c;
    det_info_t             info_next;

    always_comb
    begin
        mag_c   = sum_reg[EW-1] ? -sum_reg : sum_reg;
        rsum_c  = {1'b0, mag_reg} + ROUND_HALF;
        subst_c = (subst == '0) ? CW'(1) : subst;
        if (r_reg == '0)
        begin
            // Determinant rounds to zero: divide by the substitute instead.
            info_next.det      = $signed(DW'(subst_c));
            info_next.singular = 1'b1;
        end
        else
        begin
            info_next.det      = sign_g_reg ? -$signed(DW'(r_reg)) : $signed(DW'(r_reg));
            info_next.singular = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DSTG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < DSTG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adj_pipe_reg[0] <= adj;
            for (int s = 1; s < DSTG; s++)
            begin
                adj_pipe_reg[s] <= adj_pipe_reg[s-1];
            end
            // Each cofactor used for the determinant is split so no multiply is wider than 24 by 26.
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j]  <= row0[j] * $signed({1'b0, adj[3*j][LOW-1:0]});
                phi_reg[j]  <= row0[j] * $signed(adj[3*j][AW-1:LOW]);
                term_reg[j] <= (TW'(phi_reg[j]) <<< LOW) + TW'(plo_reg[j]);
            end
            sum_reg    <= EW'(term_reg[0]) + EW'(term_reg[1]) + EW'(term_reg[2]);
            sign_f_reg <= sum_reg[EW-1];
            mag_reg    <= mag_c[EW-2:0];
            sign_g_reg <= sign_f_reg;
            r_reg      <= rsum_c[FRAC_DROP+RW-1:FRAC_DROP];
            info_reg   <= info_next;
        end
    end

    assign out_valid = vld_reg[DSTG-1];
    assign adj_out   = adj_pipe_reg[DSTG-1];
    assign info      = info_reg;

endmodule

// File: hdl/mi3inv_div.sv
`timescale 1ns / 1ps

module mi3inv_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  mi3inv_pkg::adj_arr_t  adj,
    input  mi3inv_pkg::det_info_t info_in,
    output logic                  out_valid,
    output mi3inv_pkg::inv_arr_t  inv,
    output mi3inv_pkg::det_info_t info_out,
    output logic                  saturated
);
    import mi3inv_pkg::*;

    // Setup stage.
    logic [NW-1:0] n_reg [NE];
    logic [RW-1:0] dm_set_reg [NE];
    logic          neg_set_reg [NE];
    det_info_t     info_set_reg;
    logic          vld_set_reg;

    // Range check and one quotient bit per stage.
    logic [NW-1:0] rem_reg [NE][QB+1];
    logic [RW-1:0] dm_reg  [NE][QB+1];
    logic [QB-1:0] q_reg   [NE][QB+1];
    logic          neg_reg [NE][QB+1];
    logic          big_reg [NE][QB+1];
    logic          vld_reg [QB+1];
    det_info_t     info_reg [QB+1];

    // Output register.
    inv_arr_t      inv_reg;
    logic          sat_reg;
    det_info_t     info_out_reg;
    logic          vld_out_reg;

    logic [AW-1:0] amag_c [NE];
    logic [DW-1:0] dmag_c;
    logic [NW-1:0] n_c [NE];
    logic [SW-1:0] sh_c [NE][QB];
    logic          ge_c [NE][QB];
    logic [NW-1:0] rem_c [NE][QB];
    logic [QB-1:0] q_c [NE][QB];
    inv_arr_t      inv_c;
    logic [NE-1:0] sat_c;

    always_comb
    begin
        dmag_c = info_in.det[DW-1] ? -info_in.det : info_in.det;
        for (int l = 0; l < NE; l++)
        begin
            amag_c[l] = adj[l][AW-1] ? -adj[l] : adj[l];
            n_c[l]    = {amag_c[l][AW-2:0], 16'b0} + NW'(dmag_c[RW-1:1]);
        end
    end

    // Restoring division, quotient bit QB-1-s decided in stage s.
    always_comb
    begin
        for (int l = 0; l < NE; l++)
        begin
            for (int s = 0; s < QB; s++)
            begin
                sh_c[l][s]  = SW'(dm_reg[l][s]) << (QB - 1 - s);
                ge_c[l][s]  = SW'(rem_reg[l][s]) >= sh_c[l][s];
                rem_c[l][s] = ge_c[l][s] ? rem_reg[l][s] - sh_c[l][s][NW-1:0] : rem_reg[l][s];
                q_c[l][s]   = q_reg[l][s] | (QB'(ge_c[l][s]) << (QB - 1 - s));
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NE; l++)
        begin
            sat_c[l] = 1'b0;
            if (neg_reg[l][QB] && (big_reg[l][QB] || q_reg[l][QB] != '0))
            begin
                if (big_reg[l][QB] || q_reg[l][QB] > QB'(NEG_MIN))
                begin
                    inv_c[l] = $signed(NEG_MIN);
                    sat_c[l] = 1'b1;
                end
                else
                begin
                    inv_c[l] = -$signed(q_reg[l][QB][OW-1:0]);
                end
            end
            else if (big_reg[l][QB] || q_reg[l][QB] > QB'(POS_MAX))
            begin
                inv_c[l] = $signed(POS_MAX);
                sat_c[l] = 1'b1;
            end
            else
            begin
                inv_c[l] = $signed(q_reg[l][QB][OW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_set_reg <= 1'b0;
            vld_out_reg <= 1'b0;
            for (int s = 0; s <= QB; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_set_reg <= in_valid;
            vld_reg[0]  <= vld_set_reg;
            for (int s = 0; s < QB; s++)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
            vld_out_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info_set_reg <= info_in;
            info_reg[0]  <= info_set_reg;
            for (int s = 0; s < QB; s++)
            begin
                info_reg[s+1] <= info_reg[s];
            end
            info_out_reg <= info_reg[QB];
            sat_reg      <= |sat_c;
            for (int l = 0; l < NE; l++)
            begin
                n_reg[l]       <= n_c[l];
                dm_set_reg[l]  <= dmag_c[RW-1:0];
                neg_set_reg[l] <= adj[l][AW-1] ^ info_in.det[DW-1];

                // A quotient of 2^33 or more saturates whatever its low bits are.
                rem_reg[l][0] <= n_reg[l];
                dm_reg[l][0]  <= dm_set_reg[l];
                q_reg[l][0]   <= '0;
                neg_reg[l][0] <= neg_set_reg[l];
                big_reg[l][0] <= SW'(n_reg[l]) >= {dm_set_reg[l], {QB{1'b0}}};

                for (int s = 0; s < QB; s++)
                begin
                    rem_reg[l][s+1] <= rem_c[l][s];
                    dm_reg[l][s+1]  <= dm_reg[l][s];
                    q_reg[l][s+1]   <= q_c[l][s];
                    neg_reg[l][s+1] <= neg_reg[l][s];
                    big_reg[l][s+1] <= big_reg[l][s];
                end
                inv_reg[l] <= inv_c[l];
            end
        end
    end

    assign out_valid = vld_out_reg;
    assign inv       = inv_reg;
    assign info_out  = info_out_reg;
    assign saturated = sat_reg;

endmodule

// File: hdl/matrix3_inverse_with_det_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  m00 .. m22, signed Q8.16
// output    out        out_valid/ out_stall inv00 .. inv22, determinant, singular, saturated
// config    in         cfg_valid/ cfg_ready cfg_data, zero-determinant substitute
//
// One matrix is accepted per cycle while in_stall is low; the pipeline holds
// 2 cofactor stages, 6 determinant stages, and 36 divider stages, where the
// nine bit-per-stage restoring dividers set the depth.
// Reset clears every valid bit and loads the substitute with one lsb.
// A stalled output holds the whole pipeline, so in_stall follows it directly.

module matrix3_inverse_with_det_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [mi3inv_pkg::MW-1:0]  m00,
    input  logic signed [mi3inv_pkg::MW-1:0]  m01,
    input  logic signed [mi3inv_pkg::MW-1:0]  m02,
    input  logic signed [mi3inv_pkg::MW-1:0]  m10,
    input  logic signed [mi3inv_pkg::MW-1:0]  m11,
    input  logic signed [mi3inv_pkg::MW-1:0]  m12,
    input  logic signed [mi3inv_pkg::MW-1:0]  m20,
    input  logic signed [mi3inv_pkg::MW-1:0]  m21,
    input  logic signed [mi3inv_pkg::MW-1:0]  m22,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mi3inv_pkg::OW-1:0]  inv00,
    output logic signed [mi3inv_pkg::OW-1:0]  inv01,
    output logic signed [mi3inv_pkg::OW-1:0]  inv02,
    output logic signed [mi3inv_pkg::OW-1:0]  inv10,
    output logic signed [mi3inv_pkg::OW-1:0]  inv11,
    output logic signed [mi3inv_pkg::OW-1:0]  inv12,
    output logic signed [mi3inv_pkg::OW-1:0]  inv20,
    output logic signed [mi3inv_pkg::OW-1:0]  inv21,
    output logic signed [mi3inv_pkg::OW-1:0]  inv22,
    output logic signed [mi3inv_pkg::DW-1:0]  determinant,
    output logic                              singular,
    output logic                              saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mi3inv_pkg::CW-1:0]         cfg_data
);
    import mi3inv_pkg::*;

    logic [CW-1:0] subst_reg;
    logic          en;
    mat_t          m_in;
    logic          cof_valid;
    adj_arr_t      cof_adj;
    row_t          cof_row;
    logic          det_valid;
    adj_arr_t      det_adj;
    det_info_t     det_info;
    inv_arr_t      inv;
    det_info_t     out_info;

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subst_reg <= CW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            subst_reg <= cfg_data;
        end
    end

    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    mi3inv_cof u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .m         (m_in),
        .out_valid (cof_valid),
        .adj       (cof_adj),
        .row0      (cof_row)
    );

    mi3inv_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cof_valid),
        .adj       (cof_adj),
        .row0      (cof_row),
        .subst     (subst_reg),
        .out_valid (det_valid),
        .adj_out   (det_adj),
        .info      (det_info)
    );

    mi3inv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (det_valid),
        .adj       (det_adj),
        .info_in   (det_info),
        .out_valid (out_valid),
        .inv       (inv),
        .info_out  (out_info),
        .saturated (saturated)
    );

    assign inv00       = inv[0];
    assign inv01       = inv[1];
    assign inv02       = inv[2];
    assign inv10       = inv[3];
    assign inv11       = inv[4];
    assign inv12       = inv[5];
    assign inv20       = inv[6];
    assign inv21       = inv[7];
    assign inv22       = inv[8];
    assign determinant = out_info.det;
    assign singular    = out_info.singular;

    // The substitute is never below one lsb, so a singular result is positive.
    a_singular_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> determinant > 0)
        else $error("singular result carries a non-positive determinant");

    a_regular_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !singular |-> determinant != 0)
        else $error("regular result carries a zero determinant");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while the pipeline is held");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mi3inv_pkg::*;

    localparam int PIPE_DEPTH = 44;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic signed [MW-1:0] m [NE];
    } matrix_t;

    typedef struct {
        logic signed [OW-1:0] inv [NE];
        logic signed [DW-1:0] det;
        logic                 singular;
        logic                 saturated;
    } inverse_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic out_valid;
    logic out_stall;
    logic signed [OW-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic signed [DW-1:0] determinant;
    logic singular;
    logic saturated;
    logic cfg_valid;
    logic cfg_ready;
    logic [CW-1:0] cfg_data;

    matrix3_inverse_with_det_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .out_valid(out_valid), .out_stall(out_stall),
        .inv00(inv00), .inv01(inv01), .inv02(inv02), .inv10(inv10), .inv11(inv11),
        .inv12(inv12), .inv20(inv20), .inv21(inv21), .inv22(inv22),
        .determinant(determinant), .singular(singular), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    matrix_t  pending_matrices [$];
    inverse_t expected_inverses [$];
    logic [CW-1:0] substitute_value;
    int  mismatch_count;
    int  idle_cycles;
    bit  quiet_phase;
    int  hold_off_request;
    int  hold_off_left;
    int  in_gap;
    int  out_gap;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rounded Q16.16 quotient of one adjugate entry over the determinant.
    function automatic logic signed [OW-1:0] divide_cofactor(
        input logic signed [AW-1:0] adj, input logic signed [DW-1:0] det, ref bit sat);
        logic [127:0] num;
        logic [127:0] dmag;
        logic [127:0] q;
        bit neg;
        num = (adj < 0) ? 128'(-adj) : 128'(adj);
        num = num << 16;
        dmag = (det < 0) ? 128'(-det) : 128'(det);
        q = (num + (dmag >> 1)) / dmag;
        neg = ((adj < 0) != (det < 0)) && (q != 0);
        if (neg) begin
            if (q > 128'h8000_0000) begin
                q = 128'h8000_0000;
                sat = 1'b1;
            end
            return OW'(-q);
        end
        if (q > 128'h7FFF_FFFF) begin
            q = 128'h7FFF_FFFF;
            sat = 1'b1;
        end
        return OW'(q);
    endfunction

    function automatic inverse_t invert_matrix(input matrix_t mat);
        inverse_t res;
        logic signed [AW-1:0] adj [NE];
        logic signed [127:0] exact;
        logic [127:0] mag;
        logic [127:0] rounded;
        bit sat;
        int k;
        k = 0;
        sat = 1'b0;
        adj[0] = mat.m[4] * mat.m[8] - mat.m[5] * mat.m[7];
        adj[1] = mat.m[2] * mat.m[7] - mat.m[1] * mat.m[8];
        adj[2] = mat.m[1] * mat.m[5] - mat.m[2] * mat.m[4];
        adj[3] = mat.m[5] * mat.m[6] - mat.m[3] * mat.m[8];
        adj[4] = mat.m[0] * mat.m[8] - mat.m[2] * mat.m[6];
        adj[5] = mat.m[2] * mat.m[3] - mat.m[0] * mat.m[5];
        adj[6] = mat.m[3] * mat.m[7] - mat.m[4] * mat.m[6];
        adj[7] = mat.m[1] * mat.m[6] - mat.m[0] * mat.m[7];
        adj[8] = mat.m[0] * mat.m[4] - mat.m[1] * mat.m[3];
        exact = 128'(mat.m[0]) * 128'(adj[0]) + 128'(mat.m[1]) * 128'(adj[3])
              + 128'(mat.m[2]) * 128'(adj[6]);
        mag = (exact < 0) ? 128'(-exact) : 128'(exact);
        rounded = (mag + 128'h8000) >> 16;
        res.det = (exact < 0) ? DW'(-rounded) : DW'(rounded);
        res.singular = 1'b0;
        if (res.det == 0) begin
            res.det = (substitute_value == 0) ? DW'(1) : DW'(substitute_value);
            res.singular = 1'b1;
        end
        for (k = 0; k < NE; k++)
            res.inv[k] = divide_cofactor(adj[k], res.det, sat);
        res.saturated = sat;
        return res;
    endfunction

    function automatic logic signed [MW-1:0] random_entry(input int mode);
        case (mode)
            0: return MW'($urandom);
            1: return MW'($signed($urandom_range(0, 2 * 65536)) - 65536);
            2: return MW'($signed($urandom_range(0, 16)) - 8);
            default: return ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t mat;
        int style;
        int k;
        int r;
        style = $urandom_range(0, 9);
        for (k = 0; k < NE; k++)
            mat.m[k] = random_entry((style < 4) ? 0 : (style < 7) ? 1 :
                                    (style < 9) ? 2 : $urandom_range(0, 3));
        // Dependent rows give exact singular matrices.
        if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(0, 2);
            for (k = 0; k < 3; k++)
                mat.m[r * 3 + k] = mat.m[((r + 1) % 3) * 3 + k];
        end
        return mat;
    endfunction

    function automatic matrix_t fill_matrix(input logic signed [MW-1:0] a, b, c, d, e, f,
                                            g, h, i);
        matrix_t mat;
        mat.m = '{a, b, c, d, e, f, g, h, i};
        return mat;
    endfunction

    task automatic write_substitute(input logic [CW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        substitute_value = value;
    endtask

    task automatic wait_drained();
        wait (pending_matrices.size() == 0 && expected_inverses.size() == 0);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic queue_directed();
        localparam logic signed [MW-1:0] ONE = 24'sh010000;
        localparam logic signed [MW-1:0] MAXV = 24'sh7FFFFF;
        localparam logic signed [MW-1:0] MINV = 24'sh800000;
        pending_matrices.push_back(fill_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        pending_matrices.push_back(fill_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_matrices.push_back(fill_matrix(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
        pending_matrices.push_back(fill_matrix(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
        pending_matrices.push_back(fill_matrix(MINV, MAXV, MINV, MAXV, MINV, MAXV,
                                               MINV, MINV, MAXV));
        // Tiny diagonal: determinant rounds to zero though it is not exactly zero.
        pending_matrices.push_back(fill_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
        // Small determinant gives large inverse entries of both signs.
        pending_matrices.push_back(fill_matrix(16, 0, 0, 0, -16, 0, 0, 0, MAXV));
        pending_matrices.push_back(fill_matrix(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE));
        pending_matrices.push_back(fill_matrix(2, 3, 0, 1, 2, 0, 0, 0, -1));
        pending_matrices.push_back(fill_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_matrices.push_back(fill_matrix(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
        pending_matrices.push_back(fill_matrix(MW'(3 * ONE), 0, 0, 0, MW'(3 * ONE), 0,
                                               0, 0, MW'(3 * ONE)));
        pending_matrices.push_back(fill_matrix(MAXV, MINV, 1, -1, MAXV, MINV, 1, 0, -1));
    endtask

    initial begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        substitute_value = 1;
        mismatch_count = 0;
        quiet_phase = 1'b0;
        hold_off_request = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        wait_drained();
        write_substitute('0);
        queue_directed();
        wait_drained();
        write_substitute({CW{1'b1}});
        queue_directed();
        for (n = 0; n < 300; n++) pending_matrices.push_back(random_matrix());
        hold_off_request = 120;
        wait_drained();
        write_substitute({1'b0, 24'h0, 32'h0001_0000});
        for (n = 0; n < 800; n++) pending_matrices.push_back(random_matrix());
        wait_drained();
        write_substitute(CW'({$urandom, $urandom}));
        for (n = 0; n < 500; n++) pending_matrices.push_back(random_matrix());
        wait_drained();
        write_substitute(CW'(1));
        quiet_phase = 1'b1;
        for (n = 0; n < 250; n++) pending_matrices.push_back(random_matrix());
        wait_drained();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender: keeps a transfer on the bus until it is accepted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else begin
            // The accepted item leaves the queue here, so the next one is at the front.
            if (in_valid && !in_stall) begin
                expected_inverses.push_back(invert_matrix(pending_matrices.pop_front()));
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                    in_gap <= $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else if (pending_matrices.size() > 0) begin
                    matrix_t nxt;
                    nxt = pending_matrices[0];
                    in_valid <= 1'b1;
                    {m00, m01, m02} <= {nxt.m[0], nxt.m[1], nxt.m[2]};
                    {m10, m11, m12} <= {nxt.m[3], nxt.m[4], nxt.m[5]};
                    {m20, m21, m22} <= {nxt.m[6], nxt.m[7], nxt.m[8]};
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, including one long hold-off.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_gap <= 0;
            hold_off_left <= 0;
        end
        else if (hold_off_request > 0) begin
            hold_off_left <= hold_off_request;
            hold_off_request = 0;
            out_stall <= 1'b1;
        end
        else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            out_stall <= (hold_off_left > 1);
        end
        else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_stall <= (out_gap > 1);
        end
        else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            out_gap <= $urandom_range(1, 3);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_inverses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transfer, det %h", determinant);
            end
            else begin
                inverse_t exp_res;
                logic signed [OW-1:0] got [NE];
                bit bad;
                exp_res = expected_inverses.pop_front();
                got = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
                bad = (exp_res.det !== determinant) || (exp_res.singular !== singular)
                   || (exp_res.saturated !== saturated);
                for (int k = 0; k < NE; k++)
                    if (exp_res.inv[k] !== got[k]) bad = 1'b1;
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"Mismatch: expected det %h sing %b sat %b,",
                                  " got det %h sing %b sat %b"},
                                 exp_res.det, exp_res.singular, exp_res.saturated,
                                 determinant, singular, saturated);
                        for (int k = 0; k < NE; k++)
                            $display("  inv[%0d] expected %h got %h", k, exp_res.inv[k], got[k]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transfer.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else if (pending_matrices.size() != 0 || expected_inverses.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule

// File: filelist.f
hdl/mi3inv_pkg.sv
hdl/mi3inv_cof.sv
hdl/mi3inv_det.sv
hdl/mi3inv_div.sv
hdl/matrix3_inverse_with_det_unit.sv
dv/tb_top.sv
